/* hdl/hlru_pkg.sv */
// Shared types and constants for the hashed LRU resume table.
package hlru_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam int DEF_ENTRIES = 16;

	localparam logic [31:0] RST_FLUSH_INTERVAL = 32'd5000;
	localparam logic [7:0]  RST_END_GUARD      = 8'd2;
	localparam logic [31:0] RST_MAX_SEC_UNKNOWN = 32'd86400;

	localparam logic [1:0] REG_FLUSH_INTERVAL = 2'd0;
	localparam logic [1:0] REG_END_GUARD      = 2'd1;
	localparam logic [1:0] REG_MAX_SEC        = 2'd2;

	localparam logic CMD_GET    = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;

	typedef struct packed {
		logic [31:0] key;
		logic        cmd;
		logic [31:0] cur_sec;
		logic [31:0] dur_sec;
		logic        force_flush;
		logic [31:0] now_ms;
	} op_t;

endpackage

/* hdl/hlru_front.sv */
// Front end: FNV-1a hashing of name bytes and issue of table operations.
module hlru_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [hlru_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [hlru_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input  logic                            s_axis_tlast,
	input  logic                            q_full,
	output logic                            q_push,
	output hlru_pkg::op_t                   q_op
);
	import hlru_pkg::*;

	logic [31:0] hash_q;
	logic        seen_q;
	logic [7:0]  nb;
	logic [31:0] hash_n;
	logic        seen_n;
	logic        acc;

	assign nb = s_axis_tdata[7:0];
	assign s_axis_tready = !q_full;
	assign acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		hash_n = hash_q;
		if (nb != 8'd0) begin
			hash_n = (hash_q ^ {24'd0, nb}) * FNV_PRIME;
		end
		seen_n = seen_q || (nb != 8'd0);
	end

	assign q_push = acc && s_axis_tlast && seen_n;

	always_comb begin
		q_op.key         = (hash_n == 32'd0) ? 32'd1 : hash_n;
		q_op.cmd         = s_axis_tuser[0];
		q_op.cur_sec     = s_axis_tdata[39:8];
		q_op.dur_sec     = s_axis_tdata[71:40];
		q_op.force_flush = s_axis_tuser[1];
		q_op.now_ms      = s_axis_tdata[103:72];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
			seen_q <= 1'b0;
		end else if (acc) begin
			if (s_axis_tlast) begin
				hash_q <= FNV_BASIS;
				seen_q <= 1'b0;
			end else begin
				hash_q <= hash_n;
				seen_q <= seen_n;
			end
		end
	end

endmodule

/* hdl/hlru_queue.sv */
// Two-deep operation queue between front and back.
module hlru_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hlru_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output hlru_pkg::op_t pop_op
);
	import hlru_pkg::*;

	op_t        mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_op = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* hdl/hlru_back.sv */
// Back end: table scan, get/update execution, flush throttle, result register.
module hlru_back #(
	parameter int ENTRIES = hlru_pkg::DEF_ENTRIES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_idx,
	input  logic [31:0]                     cfg_data,
	input  logic                            q_not_empty,
	input  hlru_pkg::op_t                   q_op,
	output logic                            q_pop,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [hlru_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [hlru_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import hlru_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [31:0] flush_int_q;
	logic [7:0]  end_guard_q;
	logic [31:0] max_sec_q;

	logic [31:0] key_mem [ENTRIES];
	logic [31:0] sec_mem [ENTRIES];
	logic [31:0] dur_mem [ENTRIES];
	logic [31:0] lu_mem  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [1:0]    state_q;
	op_t           op_q;
	logic [CW-1:0] cnt_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;

	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_valid_s1;
	logic [31:0]   rd_key_s1;
	logic [31:0]   rd_sec_s1;
	logic [31:0]   rd_dur_s1;
	logic [31:0]   rd_lu_s1;
	logic [31:0]   e_key;
	logic [31:0]   e_sec;
	logic [31:0]   e_dur;
	logic [31:0]   e_lu;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [31:0]   hit_sec_q;
	logic [31:0]   hit_dur_q;
	logic          emp_q;
	logic [IW-1:0] emp_idx_q;
	logic [IW-1:0] best_idx_q;
	logic [31:0]   best_lu_q;

	logic [31:0]   lft_q;
	logic          fvalid_q;

	logic          out_v_q;
	logic          out_found_q;
	logic [31:0]   out_sec_q;
	logic          out_flush_q;
	logic [3:0]    out_slot_q;

	logic          exec_go;
	logic [31:0]   lim;
	logic [31:0]   store;
	logic [IW-1:0] w_idx;
	logic          unchanged;
	logic          get_hit;
	logic          flush_ok;
	logic          wr_full;
	logic          wr_lu;
	logic          flush_now;

	assign rd_en = (state_q == ST_SCAN) && (cnt_q != LAST_CNT);
	assign rd_addr = cnt_q[IW-1:0];
	assign q_pop = (state_q == ST_IDLE) && q_not_empty;
	assign exec_go = (state_q == ST_EXEC) && (!out_v_q || m_axis_tready);

	// never-written entries read as zero
	assign e_key = rd_valid_s1 ? rd_key_s1 : 32'd0;
	assign e_sec = rd_valid_s1 ? rd_sec_s1 : 32'd0;
	assign e_dur = rd_valid_s1 ? rd_dur_s1 : 32'd0;
	assign e_lu  = rd_valid_s1 ? rd_lu_s1  : 32'd0;

	always_comb begin
		lim = (op_q.dur_sec > {24'd0, end_guard_q}) ?
			op_q.dur_sec - {24'd0, end_guard_q} : op_q.dur_sec;
		store = op_q.cur_sec;
		if (op_q.dur_sec != 32'd0) begin
			if (op_q.cur_sec >= lim) store = 32'd0;
		end else if (op_q.cur_sec > max_sec_q) begin
			store = 32'd0;
		end
		w_idx = hit_q ? hit_idx_q : (emp_q ? emp_idx_q : best_idx_q);
		unchanged = hit_q && (hit_sec_q == store) && (hit_dur_q == op_q.dur_sec);
		get_hit = hit_q && (hit_sec_q != 32'd0);
		flush_ok = !fvalid_q || ((op_q.now_ms - lft_q) >= flush_int_q);
		wr_full = exec_go && (op_q.cmd == CMD_UPDATE) && !unchanged;
		wr_lu = exec_go && ((op_q.cmd == CMD_UPDATE) || get_hit);
		// table just became dirty; throttled flush, unless an update forces it
		flush_now = (wr_full || (exec_go && op_q.cmd == CMD_GET && get_hit)) &&
			((op_q.cmd == CMD_UPDATE && op_q.force_flush) || flush_ok);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_s1 <= key_mem[rd_addr];
			rd_sec_s1 <= sec_mem[rd_addr];
			rd_dur_s1 <= dur_mem[rd_addr];
			rd_lu_s1 <= lu_mem[rd_addr];
			rd_valid_s1 <= valid_q[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
		if (wr_full) begin
			key_mem[w_idx] <= op_q.key;
			sec_mem[w_idx] <= store;
			dur_mem[w_idx] <= op_q.dur_sec;
		end
		if (wr_lu) begin
			lu_mem[w_idx] <= op_q.now_ms;
		end
		if (q_pop) begin
			op_q <= q_op;
		end
		if (rd_vld_s1) begin
			if (!hit_q && e_key == op_q.key) begin
				hit_idx_q <= rd_idx_s1;
				hit_sec_q <= e_sec;
				hit_dur_q <= e_dur;
			end
			if (!emp_q && e_key == 32'd0) emp_idx_q <= rd_idx_s1;
			if (rd_idx_s1 == '0 || e_lu < best_lu_q) begin
				best_idx_q <= rd_idx_s1;
				best_lu_q <= e_lu;
			end
		end
		if (exec_go) begin
			out_found_q <= (op_q.cmd == CMD_GET) && get_hit;
			out_sec_q <= ((op_q.cmd == CMD_GET) && get_hit) ? hit_sec_q : 32'd0;
			out_slot_q <= ((op_q.cmd == CMD_GET) && !get_hit) ? 4'd0 : 4'(w_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_int_q <= RST_FLUSH_INTERVAL;
			end_guard_q <= RST_END_GUARD;
			max_sec_q <= RST_MAX_SEC_UNKNOWN;
			valid_q <= '0;
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			emp_q <= 1'b0;
			lft_q <= 32'd0;
			fvalid_q <= 1'b0;
			out_v_q <= 1'b0;
			out_flush_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_FLUSH_INTERVAL: flush_int_q <= cfg_data;
					REG_END_GUARD: end_guard_q <= cfg_data[7:0];
					REG_MAX_SEC: max_sec_q <= cfg_data;
					default: ;
				endcase
			end
			rd_vld_s1 <= rd_en;
			if (rd_en) cnt_q <= cnt_q + CW'(1);
			if (rd_vld_s1) begin
				if (e_key == op_q.key) hit_q <= 1'b1;
				if (e_key == 32'd0) emp_q <= 1'b1;
			end
			if (exec_go) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						cnt_q <= '0;
						hit_q <= 1'b0;
						emp_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_CNT && !rd_vld_s1) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						out_flush_q <= flush_now;
						if (wr_full) valid_q[w_idx] <= 1'b1;
						if (flush_now) begin
							lft_q <= op_q.now_ms;
							fvalid_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {4'd0, out_slot_q, out_sec_q};
	assign m_axis_tuser = {out_flush_q, out_found_q};

endmodule

/* hdl/hashed_lru_resume_table_unit.sv */
// Top level of the hashed LRU resume table.
//  channel | dir | beat contents
//  s_axis  | in  | tdata name_byte/cur/dur/now, tuser cmd/force_flush, tlast end of name
//  m_axis  | out | tdata resume_sec/slot_used, tuser found/flush_request
//  cfg     | in  | register write: index, 32-bit data
// Name bytes are taken one per cycle while the queue is not full, and the hash
// multiplier feeds a two-deep queue. The back end takes one operation at a time,
// scanning the entry memory with one read per cycle. Reset clears the table through
// per-entry valid bits, no clearing pass. A stalled result holds; the front keeps
// hashing until the queue is full.
module hashed_lru_resume_table_unit #(
	parameter int ENTRIES = hlru_pkg::DEF_ENTRIES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] name_byte, [39:8] cur_sec, [71:40] dur_sec, [103:72] now_ms
	input  logic [hlru_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] cmd, [1] force_flush
	input  logic [hlru_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] resume_sec, [35:32] slot_used, [39:36] zero
	output logic [hlru_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] found, [1] flush_request
	output logic [hlru_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_idx,
	input  logic [31:0]                     cfg_data
);
	import hlru_pkg::*;

	logic q_full;
	logic q_push;
	op_t  push_op;
	logic q_pop;
	logic q_not_empty;
	op_t  pop_op;

	hlru_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.q_full(q_full), .q_push(q_push), .q_op(push_op)
	);

	hlru_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_op(push_op), .full(q_full),
		.pop(q_pop), .not_empty(q_not_empty), .pop_op(pop_op)
	);

	hlru_back #(.ENTRIES(ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.q_not_empty(q_not_empty), .q_op(pop_op), .q_pop(q_pop),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

endmodule

/* hdl/hlru_checker.sv */
// Port-level checks for the hashed LRU resume table, bound to the top level.
module hlru_props (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [hlru_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [hlru_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_found_sec: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] != 32'd0)
		else $error("hit reported with zero second");

	a_sec_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[31:0] != 32'd0 |-> m_axis_tuser[0])
		else $error("nonzero second without hit");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:36] == 4'd0)
		else $error("result padding not zero");

endmodule

bind hashed_lru_resume_table_unit hlru_props u_hlru_props (.*);

/* tb/hlru_checker.sv */
`timescale 1ns / 1ps
// Checker for the hashed LRU resume table: predicts each operation result and compares.
module hlru_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [103:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          results_seen
);
	import hlru_pkg::*;

	typedef struct packed {
		logic        found;
		logic [31:0] resume_sec;
		logic        flush_request;
		logic [3:0]  slot_used;
	} resume_res_t;

	resume_res_t resume_q[$];

	logic [31:0] flush_ivl;
	logic [7:0]  end_guard;
	logic [31:0] max_unknown;
	logic [31:0] hash_acc;
	logic        seen_byte;
	logic [31:0] tbl_key [16];
	logic [31:0] tbl_sec [16];
	logic [31:0] tbl_dur [16];
	logic [31:0] tbl_use [16];
	logic        dirty;
	logic        flushed_once;
	logic [31:0] last_flush;

	function automatic logic flush_check(input logic force_it, input logic [31:0] now);
		if (!dirty)
			return 1'b0;
		if (!force_it && flushed_once && (now - last_flush) < flush_ivl)
			return 1'b0;
		last_flush = now;
		flushed_once = 1'b1;
		dirty = 1'b0;
		return 1'b1;
	endfunction

	task automatic predict_beat(input logic [103:0] d, input logic [1:0] u, input logic lst);
		logic [7:0]  b;
		logic [31:0] cur, dur, now, key, keep, lim;
		int          idx;
		resume_res_t r;
		b = d[7:0];
		cur = d[39:8];
		dur = d[71:40];
		now = d[103:72];
		r = '0;
		idx = -1;
		if (b != 0) begin
			hash_acc = (hash_acc ^ {24'd0, b}) * FNV_PRIME;
			seen_byte = 1'b1;
		end
		if (!lst)
			return;
		if (!seen_byte) begin
			hash_acc = FNV_BASIS;
			return;
		end
		key = (hash_acc != 0) ? hash_acc : 32'd1;
		hash_acc = FNV_BASIS;
		seen_byte = 1'b0;
		for (int i = 15; i >= 0; i--)
			if (tbl_key[i] == key) idx = i;
		if (u[0] == CMD_GET) begin
			if (idx >= 0 && tbl_sec[idx] != 0) begin
				r.found = 1'b1;
				r.resume_sec = tbl_sec[idx];
				r.slot_used = idx[3:0];
				tbl_use[idx] = now;
				dirty = 1'b1;
				r.flush_request = flush_check(1'b0, now);
			end
		end else begin
			keep = cur;
			if (idx < 0) begin
				for (int i = 15; i >= 0; i--)
					if (tbl_key[i] == 0) idx = i;
				if (idx < 0) begin
					idx = 0;
					for (int i = 1; i < 16; i++)
						if (tbl_use[i] < tbl_use[idx]) idx = i;
				end
			end
			if (dur > 0) begin
				lim = (dur > end_guard) ? dur - end_guard : dur;
				if (cur >= lim) keep = 0;
			end else if (cur > max_unknown) begin
				keep = 0;
			end
			r.slot_used = idx[3:0];
			if (tbl_key[idx] == key && tbl_sec[idx] == keep && tbl_dur[idx] == dur) begin
				tbl_use[idx] = now;
			end else begin
				tbl_key[idx] = key;
				tbl_sec[idx] = keep;
				tbl_dur[idx] = dur;
				tbl_use[idx] = now;
				dirty = 1'b1;
				r.flush_request = flush_check(u[1], now);
			end
		end
		resume_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		resume_res_t e;
		if (!arst_n) begin
			flush_ivl = RST_FLUSH_INTERVAL;
			end_guard = RST_END_GUARD;
			max_unknown = RST_MAX_SEC_UNKNOWN;
			hash_acc = FNV_BASIS;
			seen_byte = 1'b0;
			dirty = 1'b0;
			flushed_once = 1'b0;
			last_flush = '0;
			for (int i = 0; i < 16; i++) begin
				tbl_key[i] = '0;
				tbl_sec[i] = '0;
				tbl_dur[i] = '0;
				tbl_use[i] = '0;
			end
			resume_q.delete();
			errors = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_FLUSH_INTERVAL: flush_ivl = cfg_data;
					REG_END_GUARD:      end_guard = cfg_data[7:0];
					REG_MAX_SEC:        max_unknown = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (resume_q.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = resume_q.pop_front();
					if (m_axis_tuser[0] !== e.found) begin
						$error("found: expected %0d, got %0d", e.found, m_axis_tuser[0]);
						errors++;
					end
					if (m_axis_tdata[31:0] !== e.resume_sec) begin
						$error("resume_sec: expected %0d, got %0d", e.resume_sec,
							m_axis_tdata[31:0]);
						errors++;
					end
					if (m_axis_tuser[1] !== e.flush_request) begin
						$error("flush_request: expected %0d, got %0d", e.flush_request,
							m_axis_tuser[1]);
						errors++;
					end
					if (m_axis_tdata[35:32] !== e.slot_used) begin
						$error("slot_used: expected %0d, got %0d", e.slot_used,
							m_axis_tdata[35:32]);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast);
		end
		pending = resume_q.size();
	end
endmodule

/* tb/tb_hashed_lru_resume_table_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the hashed LRU resume table: stimulus, stalls and verdict.
module tb_hashed_lru_resume_table_unit;
	import hlru_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [39:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_idx = '0;
	logic [31:0]  cfg_data = '0;
	int           errors, pending, results_seen;
	int           beats_sent = 0;
	int           hold_off = 0;
	logic         hold_go = 1'b0;
	logic         hold_done = 1'b0;
	logic [31:0]  clock_ms = 32'd100;

	// pool of names so updates and gets hit the same keys
	logic [7:0] names [24][4];
	int         name_len [24];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	hashed_lru_resume_table_unit i_dut (.*);

	hlru_checker i_chk (.*);

	// receiver: own stall pattern plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_off <= hold_off + 1;
			if (hold_off == 399) hold_done <= 1'b1;
		end else begin
			case ((results_seen / 16) % 3)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				default: m_axis_tready <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic lst, input logic cmd,
			input logic [31:0] cur, input logic [31:0] dur, input logic frc,
			input logic [31:0] now);
		s_axis_tdata <= {now, dur, cur, b};
		s_axis_tuser <= {frc, cmd};
		s_axis_tlast <= lst;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic idle_gap(input int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_and_wait();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one operation on a pooled name; occasionally embeds zero bytes
	task automatic send_op(input int n, input logic cmd, input logic [31:0] cur,
			input logic [31:0] dur, input logic frc);
		int len;
		len = name_len[n];
		clock_ms = clock_ms + $urandom_range(0, 3000);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 15) == 0)
				send_beat(8'd0, 1'b0, cmd, $urandom, $urandom, 1'($urandom_range(0, 1)),
					$urandom);
			send_beat(names[n][k], k == len - 1, cmd, cur, dur, frc, clock_ms);
		end
	endtask

	function automatic logic [31:0] rand_sec();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return $urandom;
			default: return $urandom_range(1, 5000);
		endcase
	endfunction

	task automatic random_phase(input int target);
		int stop_at, burst;
		stop_at = beats_sent + target;
		burst = 0;
		while (beats_sent < stop_at) begin
			if (burst == 0) begin
				if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 12));
				burst = $urandom_range(1, 20);
			end
			burst--;
			case ($urandom_range(0, 9))
				0: send_beat(8'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom, $urandom,
					1'($urandom_range(0, 1)), $urandom);
				1: send_beat(8'd0, 1'b1, 1'($urandom_range(0, 1)), $urandom, $urandom,
					1'($urandom_range(0, 1)), $urandom);
				2, 3, 4: send_op($urandom_range(0, 23), CMD_GET, $urandom, $urandom,
					1'($urandom_range(0, 1)));
				default: send_op($urandom_range(0, 23), CMD_UPDATE, rand_sec(),
					($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 6000),
					$urandom_range(0, 3) == 0);
			endcase
		end
	endtask

	initial begin
		for (int n = 0; n < 24; n++) begin
			name_len[n] = $urandom_range(1, 4);
			for (int k = 0; k < 4; k++) names[n][k] = 8'($urandom_range(1, 255));
		end
		names[0][0] = 8'hFF;
		names[1][0] = 8'h01;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty strings, misses, guards, unchanged update, force flush
		send_beat(8'd0, 1'b1, CMD_GET, '0, '0, 1'b0, '0);
		send_beat(8'd0, 1'b0, CMD_UPDATE, '0, '0, 1'b0, '0);
		send_beat(8'd0, 1'b1, CMD_UPDATE, '0, '0, 1'b0, '0);
		send_op(0, CMD_GET, '0, '0, 1'b0);
		send_op(0, CMD_UPDATE, 32'd50, 32'd100, 1'b0);
		send_op(0, CMD_GET, '0, '0, 1'b0);
		send_op(0, CMD_UPDATE, 32'd50, 32'd100, 1'b0);
		send_op(1, CMD_UPDATE, 32'd98, 32'd100, 1'b1);
		send_op(1, CMD_UPDATE, 32'd1, 32'd1, 1'b1);
		send_op(2, CMD_UPDATE, 32'd86400, 32'd0, 1'b0);
		send_op(3, CMD_UPDATE, 32'd86401, 32'd0, 1'b1);
		send_op(4, CMD_UPDATE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
		send_op(4, CMD_GET, '0, '0, 1'b0);
		send_beat(8'hFF, 1'b1, CMD_UPDATE, 32'd7, 32'd0, 1'b1, 32'hFFFFFFFF);
		drain_and_wait();

		// extreme settings, then fill past capacity to force evictions
		write_reg(REG_FLUSH_INTERVAL, 32'd0);
		write_reg(REG_END_GUARD, 32'd255);
		write_reg(REG_MAX_SEC, 32'hFFFFFFFF);
		for (int n = 0; n < 24; n++)
			send_op(n, CMD_UPDATE, 32'd10 + n, 32'd0, 1'b0);
		// long receiver hold-off while the sender keeps pushing
		hold_go <= 1'b1;
		random_phase(300);
		drain_and_wait();

		write_reg(REG_FLUSH_INTERVAL, 32'hFFFFFFFF);
		write_reg(REG_END_GUARD, 32'd0);
		write_reg(REG_MAX_SEC, 32'd0);
		random_phase(500);
		drain_and_wait();

		write_reg(REG_FLUSH_INTERVAL, 32'd2000);
		write_reg(REG_END_GUARD, 32'd10);
		write_reg(REG_MAX_SEC, 32'd3000);
		random_phase(1000);
		drain_and_wait();

		$display("covered %0d input beats, %0d result beats over four register settings",
			beats_sent, results_seen);
		if (errors == 0)
			$display("tb_hashed_lru_resume_table_unit: done, clean");
		else
			$display("tb_hashed_lru_resume_table_unit: done, errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_hashed_lru_resume_table_unit: done, errors");
		$finish;
	end
endmodule
